// ----- src/pgg_pkg.sv -----
// ----------------------------------------------------------------------------
// pgg_pkg
// Shared constants, types and elaboration-time tables of the pitch glide
// generator: log2 / exp2 fixed-point constants and sequencer states.
// ----------------------------------------------------------------------------
package pgg_pkg;

  localparam int unsigned SAMPLE_RATE = 48000;
  localparam int unsigned BUFFER_SIZE = 256;

  localparam int unsigned PITCH_W = 20;
  localparam int unsigned OFS_W   = 21;
  localparam int unsigned PROG_W  = 25;
  localparam int unsigned LT_W    = 24;
  localparam int unsigned BASE_W  = 25;
  localparam int unsigned V_W     = 26;
  localparam int unsigned DIV_W   = 32;
  localparam int unsigned DEN_W   = 11;

  localparam logic [PROG_W-1:0] ONE_Q24  = 25'h100_0000;
  localparam logic [PROG_W-1:0] STEP_MAX = 25'h1ff_ffff;
  localparam logic [LT_W-1:0]   LOG2_50_Q16 = 24'd369876;

  // x / 1270 == ((x >> 1) * PROP_RECIP) >> 41 for any 32-bit x
  localparam logic [31:0] PROP_RECIP = 32'(((64'd1 << 41) + 64'd634) / 64'd635);

  localparam logic [BASE_W-1:0] STEP_BASE =
    BASE_W'((64'(BUFFER_SIZE) << 24) / 64'(SAMPLE_RATE));

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef enum logic [2:0] {
    REG_FLAGS   = 3'd0,
    REG_TIME    = 3'd1,
    REG_PRATE   = 3'd2,
    REG_PDEPTH  = 3'd3,
    REG_STRETCH = 3'd4,
    REG_THRESH  = 3'd5,
    REG_GLISS   = 3'd6
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_PMUL, ST_PDIV, ST_PADD, ST_ESET, ST_EXP, ST_EACC,
    ST_BASE, ST_STEP, ST_TICK, ST_CMUL, ST_CFIN, ST_GMUL, ST_GSEL, ST_HMUL,
    ST_HDIV, ST_SMUL, ST_SDIV, ST_DIV, ST_FIN, ST_DONE
  } state_e;

  typedef logic [19:0]        lt_tab_t   [128];
  typedef logic signed [20:0] la_tab_t   [128];
  typedef logic [17:0]        str_tab_t  [128];
  typedef logic [30:0]        root_tab_t [16];

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = 64'd0;
    b = 64'd1 << 62;
    x = v;
    for (int j = 0; j < 32; j++) begin
      if (b > x) b = b >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (b != 64'd0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
    end
    return r;
  endfunction

  function automatic longint log2q(logic [63:0] n);
    int          p;
    logic        found;
    logic [63:0] y;
    longint      res;
    p = 0;
    found = 1'b0;
    for (int j = 63; j >= 0; j--) begin
      if (!found && n[j]) begin
        p = j;
        found = 1'b1;
      end
    end
    y = (p > 30) ? (n >> (p - 30)) : (n << (30 - p));
    res = longint'(p) * 65536;
    for (int i = 15; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        res = res + (longint'(1) << i);
      end
    end
    return res;
  endfunction

  function automatic lt_tab_t gen_lt_tab();
    lt_tab_t tab;
    for (int t = 0; t < 128; t++) tab[t] = 20'((64'd435412 * 64'(t)) / 64'd127);
    return tab;
  endfunction

  function automatic la_tab_t gen_la_tab();
    la_tab_t tab;
    for (int r = 0; r < 128; r++) begin
      tab[r] = 21'(log2q(64'(300 * r + 635)) - log2q(64'd12700));
    end
    return tab;
  endfunction

  function automatic str_tab_t gen_str_tab();
    str_tab_t tab;
    for (int u = 0; u < 128; u++) begin
      if (u >= 64) tab[u] = 18'((64'd217706 * 64'(u - 64)) / 64'd63);
      else         tab[u] = 18'((64'd217706 * 64'(64 - u)) / 64'd64);
    end
    return tab;
  endfunction

  function automatic root_tab_t gen_roots();
    root_tab_t   tab;
    logic [63:0] root;
    root = 64'd2 << 30;
    for (int i = 0; i < 16; i++) begin
      root = isqrt64(root << 30);
      tab[i] = root[30:0];
    end
    return tab;
  endfunction

  localparam lt_tab_t   LT_TAB  = gen_lt_tab();
  localparam la_tab_t   LA_TAB  = gen_la_tab();
  localparam str_tab_t  STR_TAB = gen_str_tab();
  localparam root_tab_t ROOTS   = gen_roots();

endpackage

// ----- src/pitch_glide_generator.sv -----
// ----------------------------------------------------------------------------
// pitch_glide_generator
// start is rejected, plain, or with proportional time; tick is idle, continuous,
// glissando hold or glissando slide
// one transaction at a time: shared multiplier and serial divider
// async reset loads register defaults and clears the sequencer and glide progress state
// ----------------------------------------------------------------------------
module pitch_glide_generator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // running_note[0], old_pitch[20:1], old_glide_pitch[40:21], new_pitch[60:41]
  input  logic [63:0] s_axis_tdata_i,
  // command[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // active[0], pitch_offset[21:1]
  output logic [23:0] m_axis_tdata_o
);
  import pgg_pkg::*;

  logic [3:0] flags_q;
  logic [6:0] gtime_q, prate_q, pdepth_q, stretch_q, thresh_q, gliss_q;

  state_e state_q, state_d, after_q, after_d;

  logic                 run_q, run_d;
  logic [PITCH_W-1:0]   po_q, pg_q, pn_q, po_d, pg_d, pn_d;
  logic                 glide_on_q, glide_on_d;
  logic [PROG_W-1:0]    progress_q, progress_d, step_q, step_d;
  logic [OFS_W-1:0]     start_q, start_d, cur_q, cur_d;
  logic [6:0]           hold_q, hold_d;
  logic [7:0]           semis_q, semis_d;
  logic signed [LT_W-1:0] lt_q, lt_d;
  logic [LT_W-1:0]      e_q, e_d;
  logic [30:0]          acc_q, acc_d;
  logic [3:0]           exp_cnt_q, exp_cnt_d;
  logic                 psign_q, psign_d;
  logic [7:0]           c_q, c_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DEN_W-1:0]     rem_q, rem_d, den_q, den_d;
  logic [4:0]           div_cnt_q, div_cnt_d;
  logic [63:0]          mul_p_q;
  logic [31:0]          mul_a, mul_b;
  logic                 mv_q, mv_d, oact_q, oact_d;
  logic [OFS_W-1:0]     oofs_q, oofs_d;

  // start decision
  logic [20:0] dg_raw, dn_raw;
  logic [19:0] adg, adn, mag;
  logic        down, up, reject, str_on;
  logic [23:0] adn12, thr_w;
  logic signed [LT_W-1:0] lt0;
  logic [24:0] semi_sum;
  logic [21:0] pdiff;
  logic [20:0] pmag;
  logic [11:0] pscale;

  // tick helpers
  logic [25:0] prog_sum;
  logic [23:0] gf;
  logic [7:0]  gc;
  logic [30:0] f127;
  logic [31:0] slide_t;
  logic [19:0] rem20;

  // divider step
  logic [DEN_W:0] div_r;
  logic           div_ge;

  // step finish
  logic [V_W-1:0]    v_w, vsh;
  logic signed [7:0] k_w;
  logic [7:0]        nk;
  logic [V_W+23:0]   vwide;
  logic [PROG_W-1:0] step_w;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = mv_q;
  assign m_axis_tdata_o  = {2'b00, oofs_q, oact_q};

  assign dg_raw = {1'b0, pg_q} - {1'b0, pn_q};
  assign dn_raw = {1'b0, po_q} - {1'b0, pn_q};
  assign adg    = dg_raw[20] ? 20'(-dg_raw) : dg_raw[19:0];
  assign adn    = dn_raw[20] ? 20'(-dn_raw) : dn_raw[19:0];
  assign down   = pn_q < po_q;
  assign up     = pn_q > po_q;
  assign adn12  = 24'(adn) * 24'd12;
  assign thr_w  = {1'b0, thresh_q, 16'h0000};
  assign str_on = ((stretch_q >= 7'd64) && down) || ((stretch_q < 7'd64) && up);
  assign reject = !flags_q[0] || (flags_q[1] && !run_q) || (po_q == pn_q) ||
                  ((stretch_q == 7'd127) && down) || ((stretch_q == 7'd0) && up) ||
                  (!flags_q[3] && (adn12 > thr_w)) || (flags_q[3] && (adn12 < thr_w));
  assign lt0 = 24'(LT_TAB[gtime_q]) - LOG2_50_Q16 - (str_on ? 24'(STR_TAB[stretch_q]) : 24'd0);
  assign semi_sum = 25'(adg) * 25'd12 + 25'd65535;
  assign pdiff  = {2'b00, adg} - {LA_TAB[prate_q][20], LA_TAB[prate_q]};
  assign pmag   = pdiff[21] ? 21'(-pdiff) : pdiff[20:0];
  assign pscale = {1'b0, pdepth_q, 4'h0} + 12'd254;

  assign mag      = start_q[20] ? 20'(-start_q) : start_q[19:0];
  assign prog_sum = 26'(progress_q) + 26'(step_q);
  assign gc       = mul_p_q[31:24];
  assign gf       = mul_p_q[23:0];
  assign f127     = {gf, 7'h00} - {7'h00, gf};
  assign slide_t  = {8'(semis_q - c_q), 24'h000000} - quo_q;
  assign rem20    = quo_q[19:0];

  assign div_r  = {rem_q, quo_q[DIV_W-1]};
  assign div_ge = div_r >= {1'b0, den_q};

  assign v_w   = mul_p_q[16 +: V_W];
  assign k_w   = $signed(e_q[23:16]);
  assign nk    = 8'(-k_w);
  assign vwide = (V_W+24)'(v_w) << k_w[4:0];
  assign vsh   = (nk >= 8'(V_W)) ? '0 : (v_w >> nk[4:0]);

  always_comb begin
    if (!k_w[7]) begin
      if (k_w >= 8'sd25) step_w = (v_w != '0) ? STEP_MAX : '0;
      else step_w = (vwide > (V_W+24)'(STEP_MAX)) ? STEP_MAX : vwide[PROG_W-1:0];
    end else begin
      step_w = (vsh > V_W'(STEP_MAX)) ? STEP_MAX : vsh[PROG_W-1:0];
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_PMUL: begin
        mul_a = 32'(pmag);
        mul_b = 32'(pscale);
      end
      ST_PDIV: begin
        mul_a = 32'(mul_p_q[31:1]);
        mul_b = PROP_RECIP;
      end
      ST_EXP: begin
        mul_a = 32'(acc_q);
        mul_b = 32'(ROOTS[exp_cnt_q]);
      end
      ST_BASE: begin
        mul_a = 32'(STEP_BASE);
        mul_b = 32'(acc_q >> 14);
      end
      ST_CMUL: begin
        mul_a = 32'(mag);
        mul_b = 32'(ONE_Q24 - progress_q);
      end
      ST_GMUL: begin
        mul_a = 32'(progress_q);
        mul_b = 32'(semis_q);
      end
      ST_HMUL: begin
        mul_a = 32'(mag);
        mul_b = 32'(semis_q - c_q);
      end
      ST_SMUL: begin
        mul_a = 32'(mag);
        mul_b = slide_t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_d    = state_q;
    after_d    = after_q;
    run_d      = run_q;
    po_d       = po_q;
    pg_d       = pg_q;
    pn_d       = pn_q;
    glide_on_d = glide_on_q;
    progress_d = progress_q;
    step_d     = step_q;
    start_d    = start_q;
    cur_d      = cur_q;
    hold_d     = hold_q;
    semis_d    = semis_q;
    lt_d       = lt_q;
    e_d        = e_q;
    acc_d      = acc_q;
    exp_cnt_d  = exp_cnt_q;
    psign_d    = psign_q;
    c_d        = c_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    den_d      = den_q;
    div_cnt_d  = div_cnt_q;
    mv_d       = mv_q && !m_axis_tready_i;
    oact_d     = oact_q;
    oofs_d     = oofs_q;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          run_d   = s_axis_tdata_i[0];
          po_d    = s_axis_tdata_i[20:1];
          pg_d    = s_axis_tdata_i[40:21];
          pn_d    = s_axis_tdata_i[60:41];
          state_d = (s_axis_tuser_i == CMD_TICK) ? ST_TICK : ST_START;
        end
      end
      ST_START: begin
        glide_on_d = 1'b0;
        cur_d      = '0;
        progress_d = '0;
        step_d     = '0;
        if (reject) begin
          state_d = ST_DONE;
        end else begin
          hold_d  = gliss_q;
          semis_d = semi_sum[23:16];
          start_d = dg_raw;
          cur_d   = dg_raw;
          lt_d    = lt0;
          state_d = flags_q[2] ? ST_PMUL : ST_ESET;
        end
      end
      ST_PMUL: begin
        psign_d = pdiff[21];
        state_d = ST_PDIV;
      end
      ST_PDIV: begin
        state_d = ST_PADD;
      end
      ST_PADD: begin
        lt_d    = psign_q ? (lt_q - 24'(mul_p_q[63:41])) : (lt_q + 24'(mul_p_q[63:41]));
        state_d = ST_ESET;
      end
      ST_ESET: begin
        e_d       = 24'(-lt_q);
        acc_d     = 31'h4000_0000;
        exp_cnt_d = '0;
        state_d   = ST_EXP;
      end
      ST_EXP: begin
        state_d = ST_EACC;
      end
      ST_EACC: begin
        if (e_q[4'd15 - exp_cnt_q]) acc_d = mul_p_q[60:30];
        exp_cnt_d = exp_cnt_q + 4'd1;
        state_d   = (exp_cnt_q == 4'd15) ? ST_BASE : ST_EXP;
      end
      ST_BASE: begin
        state_d = ST_STEP;
      end
      ST_STEP: begin
        step_d     = (step_w == '0) ? 25'd1 : step_w;
        glide_on_d = 1'b1;
        state_d    = ST_DONE;
      end
      ST_TICK: begin
        if (!glide_on_q) begin
          state_d = ST_DONE;
        end else begin
          if (prog_sum > 26'(ONE_Q24)) begin
            progress_d = ONE_Q24;
            glide_on_d = 1'b0;
          end else begin
            progress_d = prog_sum[PROG_W-1:0];
          end
          state_d = ((semis_q != 8'd0) && (hold_q != 7'd0)) ? ST_GMUL : ST_CMUL;
        end
      end
      ST_CMUL: begin
        state_d = ST_CFIN;
      end
      ST_CFIN: begin
        cur_d   = start_q[20] ? 21'(-{1'b0, mul_p_q[43:24]}) : {1'b0, mul_p_q[43:24]};
        state_d = ST_DONE;
      end
      ST_GMUL: begin
        state_d = ST_GSEL;
      end
      ST_GSEL: begin
        c_d = gc;
        if (f127 < {hold_q, 24'h000000}) begin
          if (gc >= semis_q) begin
            cur_d   = '0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_HMUL;
          end
        end else if ((9'(gc) + 9'd1) >= 9'(semis_q)) begin
          cur_d   = '0;
          state_d = ST_DONE;
        end else begin
          quo_d     = 32'(f127 - {hold_q, 24'h000000});
          rem_d     = '0;
          den_d     = 11'd127 - 11'(hold_q);
          div_cnt_d = '0;
          after_d   = ST_SMUL;
          state_d   = ST_DIV;
        end
      end
      ST_HMUL: begin
        state_d = ST_HDIV;
      end
      ST_HDIV: begin
        quo_d     = mul_p_q[31:0];
        rem_d     = '0;
        den_d     = 11'(semis_q);
        div_cnt_d = '0;
        after_d   = ST_FIN;
        state_d   = ST_DIV;
      end
      ST_SMUL: begin
        state_d = ST_SDIV;
      end
      ST_SDIV: begin
        quo_d     = mul_p_q[55:24];
        rem_d     = '0;
        den_d     = 11'(semis_q);
        div_cnt_d = '0;
        after_d   = ST_FIN;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        rem_d     = div_ge ? DEN_W'(div_r - {1'b0, den_q}) : div_r[DEN_W-1:0];
        quo_d     = {quo_q[DIV_W-2:0], div_ge};
        div_cnt_d = div_cnt_q + 5'd1;
        if (div_cnt_q == 5'd31) state_d = after_q;
      end
      ST_FIN: begin
        cur_d   = start_q[20] ? 21'(-{1'b0, rem20}) : {1'b0, rem20};
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!mv_q || m_axis_tready_i) begin
          mv_d    = 1'b1;
          oact_d  = glide_on_q;
          oofs_d  = cur_q;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= 4'd0;
      gtime_q   <= 7'd64;
      prate_q   <= 7'd80;
      pdepth_q  <= 7'd90;
      stretch_q <= 7'd64;
      thresh_q  <= 7'd3;
      gliss_q   <= 7'd0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_FLAGS:   flags_q   <= cfg_wdata_i[3:0];
        REG_TIME:    gtime_q   <= cfg_wdata_i;
        REG_PRATE:   prate_q   <= cfg_wdata_i;
        REG_PDEPTH:  pdepth_q  <= cfg_wdata_i;
        REG_STRETCH: stretch_q <= cfg_wdata_i;
        REG_THRESH:  thresh_q  <= cfg_wdata_i;
        REG_GLISS:   gliss_q   <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      after_q    <= ST_IDLE;
      glide_on_q <= 1'b0;
      progress_q <= '0;
      step_q     <= '0;
      start_q    <= '0;
      cur_q      <= '0;
      hold_q     <= '0;
      semis_q    <= '0;
      exp_cnt_q  <= '0;
      div_cnt_q  <= '0;
      mv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      after_q    <= after_d;
      glide_on_q <= glide_on_d;
      progress_q <= progress_d;
      step_q     <= step_d;
      start_q    <= start_d;
      cur_q      <= cur_d;
      hold_q     <= hold_d;
      semis_q    <= semis_d;
      exp_cnt_q  <= exp_cnt_d;
      div_cnt_q  <= div_cnt_d;
      mv_q       <= mv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    po_q    <= po_d;
    pg_q    <= pg_d;
    pn_q    <= pn_d;
    lt_q    <= lt_d;
    e_q     <= e_d;
    acc_q   <= acc_d;
    psign_q <= psign_d;
    c_q     <= c_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    oact_q  <= oact_d;
    oofs_q  <= oofs_d;
    mul_p_q <= 64'(mul_a) * 64'(mul_b);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) progress_q <= ONE_Q24)
    else $error("progress above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    glide_on_q |-> (step_q != '0))
    else $error("glide running with zero step");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DIV) |-> (div_cnt_q == 5'd0))
    else $error("divider count left running");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == ST_DONE))
    else $error("result shown outside done state");

endmodule
